FILE: rtl/four_bit_microcontroller_core_defines.svh
// assertion macros for the four-bit microcontroller core
// used by four_bit_microcontroller_core.sv, needs clk_i and rst_ni in scope
`ifndef FOUR_BIT_MICROCONTROLLER_CORE_DEFINES_SVH
`define FOUR_BIT_MICROCONTROLLER_CORE_DEFINES_SVH

// checked only out of reset
`define FBMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define FBMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/fbmc_pkg.sv
// shared types, codes and helpers of the four-bit microcontroller core
// no dependencies
package fbmc_pkg;

  localparam int unsigned RetDepthDef  = 4;
  localparam int unsigned ProgBytesDef = 4096;
  localparam int unsigned RamNibDef    = 256;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_OP, S_SKIP, S_LONG, S_TABLE
  } state_e;

  typedef enum logic [1:0] {
    ACT_EXEC, ACT_IRQ_A, ACT_LOAD, ACT_XFER
  } action_e;

  typedef enum logic [2:0] {
    ST_OK, ST_STANDBY, ST_BAD_OP, ST_BAD_PORT, ST_OVERFLOW, ST_UNDERFLOW, ST_SHORT_XFER
  } status_e;

  localparam logic [7:0] OP_RC   = 8'h60;
  localparam logic [7:0] OP_SC   = 8'h61;
  localparam logic [7:0] OP_DI   = 8'h62;
  localparam logic [7:0] OP_EI   = 8'h63;
  localparam logic [7:0] OP_EXAX = 8'h64;
  localparam logic [7:0] OP_ATX  = 8'h65;
  localparam logic [7:0] OP_EXBM = 8'h66;
  localparam logic [7:0] OP_EXBL = 8'h67;
  localparam logic [7:0] OP_EX   = 8'h68;
  localparam logic [7:0] OP_PAT  = 8'h6A;
  localparam logic [7:0] OP_TABL = 8'h6B;
  localparam logic [7:0] OP_TB   = 8'h6D;
  localparam logic [7:0] OP_TC   = 8'h6E;
  localparam logic [7:0] OP_TAM  = 8'h6F;
  localparam logic [7:0] OP_OUTL = 8'h71;
  localparam logic [7:0] OP_IN   = 8'h74;
  localparam logic [7:0] OP_OUT  = 8'h75;
  localparam logic [7:0] OP_HALT = 8'h77;
  localparam logic [7:0] OP_INCB = 8'h78;
  localparam logic [7:0] OP_COMA = 8'h79;
  localparam logic [7:0] OP_ADD  = 8'h7A;
  localparam logic [7:0] OP_ADC  = 8'h7B;
  localparam logic [7:0] OP_DECB = 8'h7C;
  localparam logic [7:0] OP_RTN  = 8'h7D;
  localparam logic [7:0] OP_RTNS = 8'h7E;
  localparam logic [7:0] OP_RTNI = 8'h7F;

  localparam logic [3:0] PORT_P0    = 4'd0;
  localparam logic [3:0] PORT_P2    = 4'd2;
  localparam logic [3:0] PORT_CONST = 4'd3;
  localparam logic [3:0] PORT_P4    = 4'd4;
  localparam logic [3:0] PORT_SEC   = 4'd5;
  localparam logic [3:0] PORT_P6    = 4'd6;
  localparam logic [3:0] PORT_XFER  = 4'd7;
  localparam logic [3:0] PORT_P9    = 4'd9;
  localparam logic [3:0] PORT_JOY   = 4'd10;
  localparam logic [3:0] PORT_IE    = 4'd14;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
    logic       used;
  } port_rd_t;

  // offset wraps inside the page
  function automatic logic [11:0] pc_adv(input logic [11:0] pc);
    return {pc[11:6], pc[5:0] + 6'd1};
  endfunction

  function automatic port_rd_t port_rd(input logic [3:0] port, input logic [3:0] nib,
                                       input logic [1:0] tb, input logic [3:0] joy);
    port_rd_t r;
    r = '0;
    r.ok = 1'b1;
    case (port)
      PORT_CONST: r.val = 4'hA;
      PORT_P4:    r.val = 4'h8;
      PORT_SEC: begin
        r.val  = nib;
        r.used = 1'b1;
      end
      PORT_XFER:  r.val = {2'b00, tb};
      PORT_P9:    r.val = 4'hF;
      PORT_JOY:   r.val = joy;
      default:    r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/four_bit_microcontroller_core.sv
// four-bit microcontroller core: program store, nibble ram, registers and sequencer
// depends on fbmc_pkg and four_bit_microcontroller_core_defines.svh
//
// channel | dir | tdata bits (lsb first)
// s_axis  | in  | action, rom_address, rom_data, port_in_value, xfer_is_read, xfer_is_wide
// m_axis  | out | status, port_write_valid, port_number, port_write_data, port_in_used,
//         |     | dma_request, dma_from_core, program_counter, accumulator
//
// load, interrupt and transfer-bit items end in the fetch state, a plain instruction in
// the op state, one with a skip, a two-byte jump or a table fetch in the skip, long or
// table state: program bytes pass the single, registered read port of the program store.
// reset clears registers and the ram valid bits at once; the program store is not cleared.
// a new item is taken only while the output register is empty or its result is taken.
`include "four_bit_microcontroller_core_defines.svh"

module four_bit_microcontroller_core #(
  parameter int unsigned RETURN_DEPTH  = fbmc_pkg::RetDepthDef,
  parameter int unsigned PROGRAM_BYTES = fbmc_pkg::ProgBytesDef,
  parameter int unsigned RAM_NIBBLES   = fbmc_pkg::RamNibDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], rom_address[13:2], rom_data[21:14], port_in_value[25:22],
  // xfer_is_read[26], xfer_is_wide[27], zero[31:28]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], port_write_valid[3], port_number[7:4], port_write_data[11:8],
  // port_in_used[12], dma_request[13], dma_from_core[14], program_counter[26:15],
  // accumulator[30:27], zero[31]
  output logic [31:0] m_axis_tdata
);
  import fbmc_pkg::*;

  localparam int unsigned SLW = $clog2(RETURN_DEPTH + 1);
  localparam int unsigned SIW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
  localparam int unsigned PAW = $clog2(PROGRAM_BYTES);
  localparam int unsigned RAW = $clog2(RAM_NIBBLES);

  typedef struct packed {
    logic [11:0]    pc;
    logic           stby;
    logic           ime;
    logic [SLW-1:0] sl;
    logic           push;
    logic [11:0]    pval;
    logic           ovf;
  } irq_t;

  function automatic irq_t irq_chk(input logic [11:0] pc, input logic [3:0] ie,
                                   input logic [3:0] fl, input logic stby,
                                   input logic ime, input logic [SLW-1:0] sl);
    irq_t       r;
    logic [3:0] pend;
    logic [5:0] off;
    r      = '0;
    r.pc   = pc;
    r.stby = stby;
    r.ime  = ime;
    r.sl   = sl;
    pend   = ie & fl;
    if (pend != 4'd0) begin
      if (stby) begin
        r.stby = 1'b0;
        r.pc   = 12'h0C0;
      end
      if (ime) begin
        if (sl >= SLW'(RETURN_DEPTH)) begin
          r.ovf = 1'b1;
        end else begin
          r.push = 1'b1;
          r.pval = r.pc;
          r.sl   = sl + SLW'(1);
          off    = r.pc[5:0];
          if (pend[0]) off = 6'd0;
          else if (pend[1]) off = 6'd2;
          else if (pend[2]) off = 6'd4;
          r.pc  = {6'b000010, off};
          r.ime = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // control and architectural registers
  state_e         state_q, state_d;
  logic [11:0]    pc_q, pc_d;
  logic [3:0]     a_q, a_d, x_q, x_d;
  logic [7:0]     b_q, b_d, sb_q, sb_d;
  logic           c_q, c_d, ime_q, ime_d, stby_q, stby_d;
  logic [3:0]     ie_q, ie_d, fl_q, fl_d, joy_q, joy_d;
  logic [1:0]     tb_q, tb_d;
  logic [SLW-1:0] sl_q, sl_d;
  logic [11:0]    stk_q [RETURN_DEPTH];

  // accepted item
  action_e        act_q;
  logic [11:0]    it_addr_q;
  logic [7:0]     it_data_q;
  logic [3:0]     it_nib_q;
  logic           it_rd_q, it_wide_q;
  logic [7:0]     op_q, op_d;

  // result being built
  status_e        st_q, st_d;
  logic           rw_q, rw_d, ru_q, ru_d, dma_q, dma_d, dir_q, dir_d;
  logic [3:0]     rp_q, rp_d, rd_q, rd_d;

  // output register
  logic           ov_q;
  logic [30:0]    out_q;

  // memories
  logic [7:0]     rom_mem [PROGRAM_BYTES];
  logic [7:0]     rom_q;
  logic [11:0]    rom_raddr;
  logic           rom_we;
  logic [3:0]     ram_mem [RAM_NIBBLES];
  logic           ram_vld_q [RAM_NIBBLES];
  logic [3:0]     ram_q;
  logic           ram_vq;
  logic           ram_we;
  logic [3:0]     ram_wdata;

  logic           stk_we;
  logic [SIW-1:0] stk_idx;
  logic [11:0]    stk_val;

  logic           in_fire, finish, need_skip, go_long, go_table;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, out_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_FETCH;
      S_FETCH: state_d = finish ? S_IDLE : S_OP;
      S_OP: begin
        if (need_skip) state_d = S_SKIP;
        else if (go_long) state_d = S_LONG;
        else if (go_table) state_d = S_TABLE;
        else state_d = S_IDLE;
      end
      S_SKIP, S_LONG, S_TABLE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE) && (!ov_q || m_axis_tready);
  end

  // datapath
  always_comb begin
    logic [3:0] m, mask, l;
    logic [1:0] imm;
    logic [2:0] grp;
    logic [4:0] sum;
    logic [7:0] bt, op;
    logic [3:0] pn;
    logic       pok;
    port_rd_t   pr;
    irq_t       ir;

    pc_d = pc_q; a_d = a_q; x_d = x_q; b_d = b_q; sb_d = sb_q; c_d = c_q;
    ime_d = ime_q; stby_d = stby_q; ie_d = ie_q; fl_d = fl_q; joy_d = joy_q;
    tb_d = tb_q; sl_d = sl_q; op_d = op_q;
    st_d = st_q; rw_d = rw_q; ru_d = ru_q; dma_d = dma_q; dir_d = dir_q;
    rp_d = rp_q; rd_d = rd_q;
    rom_raddr = pc_q; rom_we = 1'b0;
    ram_we = 1'b0; ram_wdata = a_q;
    stk_we = 1'b0; stk_idx = SIW'(sl_q); stk_val = pc_q;
    finish = 1'b0; need_skip = 1'b0; go_long = 1'b0; go_table = 1'b0;
    m = ram_vq ? ram_q : 4'd0;
    op = rom_q;
    mask = 4'd1 << op[1:0];
    imm = op[1:0]; grp = op[4:2];
    l = 4'd0; sum = 5'd0; bt = b_q; pn = 4'd0; pok = 1'b0;
    pr = '0; ir = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          st_d = ST_OK; rw_d = 1'b0; ru_d = 1'b0; dma_d = 1'b0; dir_d = 1'b0;
          rp_d = 4'd0; rd_d = 4'd0;
        end
      end
      S_FETCH: begin
        case (act_q)
          ACT_EXEC: begin
            if (stby_q) begin
              st_d = ST_STANDBY;
              finish = 1'b1;
            end else begin
              pc_d = pc_adv(pc_q);
            end
          end
          ACT_IRQ_A: begin
            fl_d = fl_q | 4'd1;
            ir = irq_chk(pc_q, ie_q, fl_d, stby_q, ime_q, sl_q);
            pc_d = ir.pc; stby_d = ir.stby; ime_d = ir.ime; sl_d = ir.sl;
            stk_we = ir.push; stk_val = ir.pval;
            if (ir.ovf) st_d = ST_OVERFLOW;
            finish = 1'b1;
          end
          ACT_LOAD: begin
            rom_we = ({1'b0, it_addr_q} < 13'(PROGRAM_BYTES));
            finish = 1'b1;
          end
          default: begin
            tb_d = {it_wide_q, it_rd_q};
            finish = 1'b1;
          end
        endcase
      end
      S_OP: begin
        op_d = op;
        if (op[7:5] == 3'b010) begin
          case (grp)
            3'd0: begin ram_we = 1'b1; ram_wdata = m & ~mask; end
            3'd1: begin ram_we = 1'b1; ram_wdata = m | mask; end
            3'd2: need_skip = |(m & mask);
            3'd3: begin
              pr = port_rd(b_q[3:0], it_nib_q, tb_q, joy_q);
              rp_d = b_q[3:0]; ru_d = pr.used;
              if (!pr.ok) st_d = ST_BAD_PORT;
              need_skip = pr.ok && |(pr.val & mask);
            end
            3'd4: begin a_d = m; b_d = b_q ^ {2'b00, imm, 4'd0}; end
            default: begin
              ram_we = 1'b1; ram_wdata = a_q; a_d = m;
              bt = b_q ^ {2'b00, imm, 4'd0};
              b_d = bt;
              if (grp == 3'd6) begin
                l = bt[3:0] + 4'd1; b_d = {bt[7:4], l}; need_skip = (l == 4'd0);
              end else if (grp == 3'd7) begin
                l = bt[3:0] - 4'd1; b_d = {bt[7:4], l}; need_skip = (l == 4'hF);
              end
            end
          endcase
        end else if (op[7:6] == 2'b00) begin
          case (op[5:4])
            2'd0: begin
              sum = {1'b0, a_q} + {1'b0, op[3:0]};
              a_d = sum[3:0]; need_skip = sum[4];
            end
            2'd1: a_d = op[3:0];
            2'd2: b_d = {b_q[7:4], op[3:0]};
            default: b_d = {op[3:0], b_q[3:0]};
          endcase
        end else if (op[7:6] == 2'b10) begin
          pc_d = {pc_q[11:6], op[5:0]};
        end else if (op[7:5] == 3'b110) begin
          if (sl_q >= SLW'(RETURN_DEPTH)) begin
            st_d = ST_OVERFLOW;
          end else begin
            stk_we = 1'b1; sl_d = sl_q + SLW'(1);
            pc_d = {6'b000001, op[4:0], 1'b0};
          end
        end else if (op[7:5] == 3'b111) begin
          go_long = 1'b1;
          pc_d = pc_adv(pc_q);
        end else begin
          case (op)
            OP_RC:   c_d = 1'b0;
            OP_SC:   c_d = 1'b1;
            OP_DI:   ime_d = 1'b0;
            OP_EI: begin
              ime_d = 1'b1;
              ir = irq_chk(pc_q, ie_q, fl_q, stby_q, 1'b1, sl_q);
              pc_d = ir.pc; stby_d = ir.stby; ime_d = ir.ime; sl_d = ir.sl;
              stk_we = ir.push; stk_val = ir.pval;
              if (ir.ovf) st_d = ST_OVERFLOW;
            end
            OP_EXAX: begin a_d = x_q; x_d = a_q; end
            OP_ATX:  x_d = a_q;
            OP_EXBM: begin a_d = b_q[7:4]; b_d = {a_q, b_q[3:0]}; end
            OP_EXBL: begin a_d = b_q[3:0]; b_d = {b_q[7:4], a_q}; end
            OP_EX:   begin b_d = sb_q; sb_d = b_q; end
            OP_PAT: begin
              if (sl_q >= SLW'(RETURN_DEPTH)) st_d = ST_OVERFLOW;
              else go_table = 1'b1;
            end
            OP_TABL: need_skip = (a_q == b_q[3:0]);
            OP_TB: begin need_skip = fl_q[1]; fl_d = fl_q & 4'b1101; end
            OP_TC:   need_skip = c_q;
            OP_TAM:  need_skip = (a_q == m);
            OP_OUTL, OP_OUT: begin
              pn = (op == OP_OUT) ? b_q[3:0] : PORT_P0;
              rp_d = pn;
              pok = 1'b1;
              case (pn)
                PORT_P0, PORT_P2, PORT_P4, PORT_SEC, PORT_P6, PORT_P9: pok = 1'b1;
                PORT_JOY: joy_d = a_q;
                PORT_IE:  ie_d = a_q;
                default:  pok = 1'b0;
              endcase
              if (!pok) begin
                st_d = ST_BAD_PORT;
              end else begin
                rw_d = 1'b1; rd_d = a_q;
                if (pn == PORT_IE) begin
                  ir = irq_chk(pc_q, a_q, fl_q, stby_q, ime_q, sl_q);
                  pc_d = ir.pc; stby_d = ir.stby; ime_d = ir.ime; sl_d = ir.sl;
                  stk_we = ir.push; stk_val = ir.pval;
                  if (ir.ovf) st_d = ST_OVERFLOW;
                end
              end
            end
            OP_IN: begin
              pr = port_rd(b_q[3:0], it_nib_q, tb_q, joy_q);
              rp_d = b_q[3:0]; ru_d = pr.used;
              if (pr.ok) a_d = pr.val;
              else st_d = ST_BAD_PORT;
            end
            OP_HALT: begin
              stby_d = 1'b1;
              if (!tb_q[1]) st_d = ST_SHORT_XFER;
              else begin dma_d = 1'b1; dir_d = tb_q[0]; end
            end
            OP_INCB: begin
              l = b_q[3:0] + 4'd1; b_d = {b_q[7:4], l}; need_skip = (l == 4'd0);
            end
            OP_COMA: a_d = a_q ^ 4'hF;
            OP_ADD:  a_d = a_q + m;
            OP_ADC: begin
              sum = {1'b0, a_q} + {1'b0, m} + {4'd0, c_q};
              a_d = sum[3:0]; c_d = sum[4];
            end
            OP_DECB: begin
              l = b_q[3:0] - 4'd1; b_d = {b_q[7:4], l}; need_skip = (l == 4'hF);
            end
            OP_RTN, OP_RTNS, OP_RTNI: begin
              if (sl_q == '0 || sl_q > SLW'(RETURN_DEPTH)) begin
                st_d = ST_UNDERFLOW;
              end else begin
                sl_d = sl_q - SLW'(1);
                pc_d = stk_q[SIW'(sl_d)];
                if (op == OP_RTNS) need_skip = 1'b1;
                if (op == OP_RTNI) begin
                  ir = irq_chk(pc_d, ie_q, fl_q, stby_q, 1'b1, sl_d);
                  pc_d = ir.pc; stby_d = ir.stby; ime_d = ir.ime;
                  stk_idx = SIW'(sl_d); stk_we = ir.push; stk_val = ir.pval;
                  sl_d = ir.sl;
                  if (ir.ovf) st_d = ST_OVERFLOW;
                end
              end
            end
            default: st_d = ST_BAD_OP;
          endcase
        end
        // the byte after the opcode, or the table entry
        if (need_skip) rom_raddr = pc_d;
        else if (go_table) rom_raddr = {4'h1, 2'b00, x_q[1:0], a_q};
        finish = !(need_skip || go_long || go_table);
      end
      S_SKIP: begin
        pc_d = (rom_q[7:5] == 3'b111) ? pc_adv(pc_adv(pc_q)) : pc_adv(pc_q);
        finish = 1'b1;
      end
      S_LONG: begin
        if (op_q[4]) begin
          if (sl_q >= SLW'(RETURN_DEPTH)) begin
            st_d = ST_OVERFLOW;
          end else begin
            stk_we = 1'b1; sl_d = sl_q + SLW'(1);
            pc_d = {op_q[3:0], rom_q};
          end
        end else begin
          pc_d = {op_q[3:0], rom_q};
        end
        finish = 1'b1;
      end
      S_TABLE: begin
        a_d = rom_q[3:0]; x_d = rom_q[7:4];
        finish = 1'b1;
      end
      default: finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0; a_q <= '0; x_q <= '0; b_q <= '0; sb_q <= '0; c_q <= 1'b0;
      ime_q <= 1'b0; stby_q <= 1'b0; ie_q <= '0; fl_q <= '0; joy_q <= '0;
      tb_q <= '0; sl_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d; a_q <= a_d; x_q <= x_d; b_q <= b_d; sb_q <= sb_d; c_q <= c_d;
      ime_q <= ime_d; stby_q <= stby_d; ie_q <= ie_d; fl_q <= fl_d; joy_q <= joy_d;
      tb_q <= tb_d; sl_q <= sl_d;
      if (finish) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q     <= action_e'(s_axis_tdata[1:0]);
      it_addr_q <= s_axis_tdata[13:2];
      it_data_q <= s_axis_tdata[21:14];
      it_nib_q  <= s_axis_tdata[25:22];
      it_rd_q   <= s_axis_tdata[26];
      it_wide_q <= s_axis_tdata[27];
    end
    op_q <= op_d;
    st_q <= st_d; rw_q <= rw_d; ru_q <= ru_d; dma_q <= dma_d; dir_q <= dir_d;
    rp_q <= rp_d; rd_q <= rd_d;
    if (finish) begin
      out_q <= {a_d, pc_d, dir_d, dma_d, ru_d, rd_d, rp_d, rw_d, 3'(st_d)};
    end
    if (stk_we) stk_q[stk_idx] <= stk_val;
  end

  // program store, one read port with registered data
  always_ff @(posedge clk_i) begin
    if (rom_we) rom_mem[it_addr_q[PAW-1:0]] <= it_data_q;
    rom_q <= rom_mem[rom_raddr[PAW-1:0]];
  end

  // nibble ram, read at the pointer every cycle
  always_ff @(posedge clk_i) begin
    if (ram_we) ram_mem[b_q[RAW-1:0]] <= ram_wdata;
    ram_q <= ram_mem[b_q[RAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(RAM_NIBBLES); i++) ram_vld_q[i] <= 1'b0;
      ram_vq <= 1'b0;
    end else begin
      if (ram_we) ram_vld_q[b_q[RAW-1:0]] <= 1'b1;
      ram_vq <= ram_vld_q[b_q[RAW-1:0]];
    end
  end

  `FBMC_ASSERT(a_stack_bound, sl_q <= SLW'(RETURN_DEPTH), "return stack level beyond depth")
  `FBMC_ASSERT(a_accept_fetch, in_fire |=> state_q == S_FETCH, "accepted item did not start")
  `FBMC_ASSERT(a_dma_ok, m_axis_tvalid && out_q[13] |-> out_q[2:0] == 3'(ST_OK), "dma with fault")
  `FBMC_ASSERT_ALWAYS(a_no_accept_busy, s_axis_tready |-> state_q == S_IDLE, "ready while busy")

endmodule
